[design/peoc_pkg.sv]
// shared types and constants for the prime / even / odd classifier
`timescale 1ns / 1ps

package peoc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int NUMBER_WIDTH    = 32;
  localparam int CATEGORY_WIDTH  = 2;

  typedef enum logic [CATEGORY_WIDTH-1:0] {
    CAT_PRIME = 2'd0,
    CAT_EVEN  = 2'd1,
    CAT_ODD   = 2'd2
  } category_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      set_cat;
    category_t cat;
    logic      div_init;
    logic      div_step;
    logic      next_div;
    logic      load_out;
  } peoc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic le_one;
    logic is_two;
    logic odd;
    logic dsq_gt;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } peoc_status_t;

endpackage

[design/peoc_dp.sv]
// datapath: value capture, trial divisor, bit-serial remainder and result register
`timescale 1ns / 1ps

module peoc_dp #(
  parameter int VALUE_WIDTH = peoc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [peoc_pkg::NUMBER_WIDTH-1:0] number,
  input  peoc_pkg::peoc_cmd_t                      cmd,
  output peoc_pkg::peoc_status_t                   status,
  output logic [peoc_pkg::CATEGORY_WIDTH-1:0]      category,
  output logic                                     category_valid,
  input  logic                                     category_stall
);
  import peoc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]   val_in;
  logic           neg_in;

  logic [W-1:0]   value;
  logic           neg;
  logic [W-1:0]   divisor;
  logic [W:0]     dsq;
  logic [W-1:0]   rem;
  logic [W-1:0]   shreg;
  logic [CW-1:0]  cnt;
  category_t      cat_hold;

  logic [W:0]     trial;
  logic [W:0]     trial_sub;
  logic [W+2:0]   dsq_sum;

  // low bits of the input, sign taken from the top used bit; zero-extended, never negative, when wider
  generate
    if (W <= NUMBER_WIDTH) begin : g_narrow
      assign val_in = number[W-1:0];
      assign neg_in = number[W-1];
    end else begin : g_wide
      assign val_in = {{(W-NUMBER_WIDTH){1'b0}}, number};
      assign neg_in = 1'b0;
    end
  endgenerate

  assign trial     = {rem, shreg[W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  // (d+2)^2 = d^2 + 4d + 4
  assign dsq_sum   = {2'b00, dsq} + {1'b0, divisor, 2'b00} + (W+3)'(4);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= val_in;
      neg     <= neg_in;
      divisor <= W'(3);
      dsq     <= (W+1)'(9);
    end
    if (cmd.div_init) begin
      rem   <= '0;
      shreg <= value;
      cnt   <= '0;
    end
    if (cmd.div_step) begin
      rem   <= (trial >= {1'b0, divisor}) ? trial_sub[W-1:0] : trial[W-1:0];
      shreg <= {shreg[W-2:0], 1'b0};
      cnt   <= cnt + CW'(1);
    end
    if (cmd.next_div) begin
      divisor <= divisor + W'(2);
      dsq     <= dsq_sum[W:0];
    end
    if (cmd.set_cat) begin
      cat_hold <= cmd.cat;
    end
    if (cmd.load_out) begin
      category <= cat_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      category_valid <= 1'b0;
    end else if (cmd.load_out) begin
      category_valid <= 1'b1;
    end else if (!category_stall) begin
      category_valid <= 1'b0;
    end
  end

  assign status.neg      = neg;
  assign status.le_one   = (value[W-1:1] == '0);
  assign status.is_two   = (value == W'(2));
  assign status.odd      = value[0];
  assign status.dsq_gt   = (dsq > {1'b0, value});
  assign status.div_last = (cnt == CW'(W-1));
  assign status.rem_zero = (rem == '0);
  assign status.out_free = !category_valid || !category_stall;

endmodule

[design/peoc_ctrl.sv]
// controller: sequences screening, trial division and result hand-off
`timescale 1ns / 1ps

module peoc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   number_valid,
  output logic                   number_stall,
  input  peoc_pkg::peoc_status_t status,
  output peoc_pkg::peoc_cmd_t    cmd
);
  import peoc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCREEN = 6'b000010,
    ST_TEST   = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign number_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.cat    = CAT_PRIME;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (number_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCREEN;
        end
      end
      ST_SCREEN: begin
        if (status.neg || status.le_one) begin
          cmd.set_cat = 1'b1;
          cmd.cat     = status.odd ? CAT_ODD : CAT_EVEN;
          state_next  = ST_FINISH;
        end else if (status.is_two) begin
          cmd.set_cat = 1'b1;
          cmd.cat     = CAT_PRIME;
          state_next  = ST_FINISH;
        end else if (!status.odd) begin
          cmd.set_cat = 1'b1;
          cmd.cat     = CAT_EVEN;
          state_next  = ST_FINISH;
        end else begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        // divisor squared beyond the value: no factor left
        if (status.dsq_gt) begin
          cmd.set_cat = 1'b1;
          cmd.cat     = CAT_PRIME;
          state_next  = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.rem_zero) begin
          cmd.set_cat = 1'b1;
          cmd.cat     = CAT_ODD;
          state_next  = ST_FINISH;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = ST_TEST;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/prime_even_odd_classifier_unit.sv]
// top level of the prime / even / odd classifier
`timescale 1ns / 1ps

// Classifies one signed integer per request as prime (0), even and not
// prime (1) or odd and not prime (2), deciding primality by trial division.
// Input channel: number with number_valid / number_stall; a request is taken
// at a rising edge with valid high and stall low. Output channel: category
// with category_valid / category_stall, same rule.
// Only the low VALUE_WIDTH bits of number are used, sign taken from the top
// used bit; above 32 bits the input is read as unsigned.
// Sequence: capture the value, screen out negatives, 0, 1, 2 and
// even values, then for each odd divisor d = 3, 5, 7 and so on with d*d <= value
// a bound test, a bit-serial remainder over all VALUE_WIDTH bits and a check;
// then the category goes into the output register.
// The remainder unit does one subtract a cycle.
// One request is worked on at a time; number_stall is high while busy.
// A finished result sits in the output register, so a new request can be
// taken and worked on while category_stall holds the previous one.
// Reset empties the output register and returns the controller to idle.

module prime_even_odd_classifier_unit #(
  parameter int VALUE_WIDTH = peoc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [peoc_pkg::NUMBER_WIDTH-1:0] number,
  input  logic                                     number_valid,
  output logic                                     number_stall,
  output logic [peoc_pkg::CATEGORY_WIDTH-1:0]      category,
  output logic                                     category_valid,
  input  logic                                     category_stall
);
  import peoc_pkg::*;

  // command and status between controller and datapath
  peoc_cmd_t    cmd;
  peoc_status_t status;

  peoc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .status       (status),
    .cmd          (cmd)
  );

  peoc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .number         (number),
    .cmd            (cmd),
    .status         (status),
    .category       (category),
    .category_valid (category_valid),
    .category_stall (category_stall)
  );

endmodule
